### rtl/quaternion_to_rotation_matrix_unit_assert.svh
// Assertion macros used by the checker file
`ifndef QUATERNION_TO_ROTATION_MATRIX_UNIT_ASSERT_SVH
`define QUATERNION_TO_ROTATION_MATRIX_UNIT_ASSERT_SVH

// Clocked assertion, disabled while reset is held
`define QRM_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("quaternion unit check failed");

// Clocked assertion that also runs during reset
`define QRM_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("quaternion unit check failed during reset");

`endif

### rtl/qrm_pkg.sv
// Shared constants, types and helpers of the quaternion to rotation matrix unit
`default_nettype none
package qrm_pkg;
    localparam int OUT_FRAC_BITS = 14;
    localparam int IN_W  = 16;
    localparam int OUT_W = 16;
    localparam int PW    = 2 * IN_W;          // one product
    localparam int SW    = PW + 1;            // squared norm
    localparam int NW    = PW + 3;            // signed numerator
    localparam int MW    = NW - 1;            // numerator magnitude
    localparam int QB    = OUT_FRAC_BITS + 1; // quotient bits
    localparam int DW    = MW + OUT_FRAC_BITS + 1;
    localparam int NENT  = 9;

    localparam logic [QB-1:0] ONE_Q = QB'(1) << OUT_FRAC_BITS;
    localparam logic signed [OUT_W-1:0] ONE_OUT = OUT_W'(1) << OUT_FRAC_BITS;

    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [NW-1:0] num_t;
    typedef logic [SW-1:0] norm_t;
    typedef logic [DW-1:0] rem_t;
    typedef logic [QB-1:0] quo_t;
    typedef logic signed [OUT_W-1:0] ent_t;

    // sign-extend a product to numerator width
    function automatic num_t sx(input prod_t p);
        sx = {{(NW-PW){p[PW-1]}}, p};
    endfunction
endpackage
`default_nettype wire

### rtl/quaternion_to_rotation_matrix_unit.sv
// Pipelined quaternion to 3x3 rotation matrix conversion
//
//  channel | direction | ports                         | beat
//  s_      | in        | s_quat_x/y/z/w                | one quaternion
//  m_      | out       | m_r00..m_r22, m_zero_norm     | one 3x3 matrix
//
// One quaternion per cycle while m_ready does not stall; the stages are:
// products, sums, dividend prep, one restoring division step per quotient
// bit (nine dividers side by side), and the output register.
// aresetn clears all valid bits; payload registers are not reset.
// A stall at m_ready freezes every stage together; s_ready drops with it.
`default_nettype none
module quaternion_to_rotation_matrix_unit (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic signed [15:0]   s_quat_x,
    input  wire logic signed [15:0]   s_quat_y,
    input  wire logic signed [15:0]   s_quat_z,
    input  wire logic signed [15:0]   s_quat_w,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic signed [15:0]        m_r00,
    output logic signed [15:0]        m_r01,
    output logic signed [15:0]        m_r02,
    output logic signed [15:0]        m_r10,
    output logic signed [15:0]        m_r11,
    output logic signed [15:0]        m_r12,
    output logic signed [15:0]        m_r20,
    output logic signed [15:0]        m_r21,
    output logic signed [15:0]        m_r22,
    output logic                      m_zero_norm
);
    localparam int QB   = qrm_pkg::QB;
    localparam int NENT = qrm_pkg::NENT;

    logic advance;

    // stage 1: products
    logic            v1_reg;
    qrm_pkg::prod_t  xx_reg, yy_reg, zz_reg, ww_reg;
    qrm_pkg::prod_t  xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;

    // stage 2: norm and numerators
    logic            v2_reg, z2_reg;
    qrm_pkg::norm_t  s2_reg;
    qrm_pkg::num_t   n2_reg [NENT];
    qrm_pkg::num_t   n2_next [NENT];
    qrm_pkg::num_t   s_n;

    // division stages
    logic            vld_reg  [QB+1];
    logic            zero_reg [QB+1];
    qrm_pkg::norm_t  sd_reg   [QB+1];
    logic            neg_reg  [QB+1][NENT];
    qrm_pkg::rem_t   rem_reg  [QB+1][NENT];
    qrm_pkg::quo_t   quo_reg  [QB+1][NENT];
    qrm_pkg::rem_t   rem_next [QB+1][NENT];
    qrm_pkg::quo_t   quo_next [QB+1][NENT];

    // output
    logic            m_valid_reg, m_zero_reg;
    qrm_pkg::ent_t   ent_reg  [NENT];
    qrm_pkg::ent_t   ent_next [NENT];

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;

    // numerators of the nine entries
    always_comb begin
        s_n = qrm_pkg::sx(xx_reg) + qrm_pkg::sx(yy_reg)
            + qrm_pkg::sx(zz_reg) + qrm_pkg::sx(ww_reg);
        n2_next[0] = s_n - ((qrm_pkg::sx(yy_reg) + qrm_pkg::sx(zz_reg)) <<< 1);
        n2_next[1] = (qrm_pkg::sx(xy_reg) + qrm_pkg::sx(wz_reg)) <<< 1;
        n2_next[2] = (qrm_pkg::sx(xz_reg) - qrm_pkg::sx(wy_reg)) <<< 1;
        n2_next[3] = (qrm_pkg::sx(xy_reg) - qrm_pkg::sx(wz_reg)) <<< 1;
        n2_next[4] = s_n - ((qrm_pkg::sx(xx_reg) + qrm_pkg::sx(zz_reg)) <<< 1);
        n2_next[5] = (qrm_pkg::sx(yz_reg) + qrm_pkg::sx(wx_reg)) <<< 1;
        n2_next[6] = (qrm_pkg::sx(xz_reg) + qrm_pkg::sx(wy_reg)) <<< 1;
        n2_next[7] = (qrm_pkg::sx(yz_reg) - qrm_pkg::sx(wx_reg)) <<< 1;
        n2_next[8] = s_n - ((qrm_pkg::sx(xx_reg) + qrm_pkg::sx(yy_reg)) <<< 1);
    end

    // one restoring step per stage, quotient bit QB-1-k at stage k
    always_comb begin
        qrm_pkg::rem_t dv;
        for (int k = 0; k < QB; k++) begin
            dv = qrm_pkg::rem_t'(sd_reg[k]) << (QB - 1 - k);
            for (int e = 0; e < NENT; e++) begin
                if (rem_reg[k][e] >= dv) begin
                    rem_next[k+1][e] = rem_reg[k][e] - dv;
                    quo_next[k+1][e] = {quo_reg[k][e][QB-2:0], 1'b1};
                end else begin
                    rem_next[k+1][e] = rem_reg[k][e];
                    quo_next[k+1][e] = {quo_reg[k][e][QB-2:0], 1'b0};
                end
            end
        end
        for (int e = 0; e < NENT; e++) begin
            rem_next[0][e] = '0;
            quo_next[0][e] = '0;
        end
    end

    // clamp, restore sign, substitute identity for a zero quaternion
    always_comb begin
        qrm_pkg::quo_t qc;
        for (int e = 0; e < NENT; e++) begin
            qc = (quo_reg[QB][e] > qrm_pkg::ONE_Q) ? qrm_pkg::ONE_Q : quo_reg[QB][e];
            if (zero_reg[QB]) begin
                ent_next[e] = (e == 0 || e == 4 || e == 8) ? qrm_pkg::ONE_OUT : '0;
            end else if (neg_reg[QB][e]) begin
                ent_next[e] = -qrm_pkg::ent_t'(qc);
            end else begin
                ent_next[e] = qrm_pkg::ent_t'(qc);
            end
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int k = 0; k <= QB; k++) vld_reg[k] <= 1'b0;
        end else if (advance) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            vld_reg[0] <= v2_reg;
            for (int k = 0; k < QB; k++) vld_reg[k+1] <= vld_reg[k];
            m_valid_reg <= vld_reg[QB];
        end
    end

    // payload, advanced together with the valid bits
    always_ff @(posedge aclk) begin
        qrm_pkg::rem_t mag;
        if (advance) begin
            xx_reg <= s_quat_x * s_quat_x;
            yy_reg <= s_quat_y * s_quat_y;
            zz_reg <= s_quat_z * s_quat_z;
            ww_reg <= s_quat_w * s_quat_w;
            xy_reg <= s_quat_x * s_quat_y;
            xz_reg <= s_quat_x * s_quat_z;
            yz_reg <= s_quat_y * s_quat_z;
            wx_reg <= s_quat_w * s_quat_x;
            wy_reg <= s_quat_w * s_quat_y;
            wz_reg <= s_quat_w * s_quat_z;

            s2_reg <= s_n[qrm_pkg::SW-1:0];
            z2_reg <= (s_n == '0);
            for (int e = 0; e < NENT; e++) n2_reg[e] <= n2_next[e];

            // dividend = |N| * 2^F + S/2
            sd_reg[0]   <= s2_reg;
            zero_reg[0] <= z2_reg;
            for (int e = 0; e < NENT; e++) begin
                mag = qrm_pkg::rem_t'(n2_reg[e][qrm_pkg::NW-1] ? -n2_reg[e] : n2_reg[e]);
                neg_reg[0][e] <= n2_reg[e][qrm_pkg::NW-1];
                rem_reg[0][e] <= (mag << qrm_pkg::OUT_FRAC_BITS)
                               + qrm_pkg::rem_t'(s2_reg >> 1);
                quo_reg[0][e] <= quo_next[0][e];
            end

            for (int k = 0; k < QB; k++) begin
                sd_reg[k+1]   <= sd_reg[k];
                zero_reg[k+1] <= zero_reg[k];
                for (int e = 0; e < NENT; e++) begin
                    neg_reg[k+1][e] <= neg_reg[k][e];
                    rem_reg[k+1][e] <= rem_next[k+1][e];
                    quo_reg[k+1][e] <= quo_next[k+1][e];
                end
            end

            m_zero_reg <= zero_reg[QB];
            for (int e = 0; e < NENT; e++) ent_reg[e] <= ent_next[e];
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_zero_norm = m_zero_reg;
    assign m_r00 = ent_reg[0];
    assign m_r01 = ent_reg[1];
    assign m_r02 = ent_reg[2];
    assign m_r10 = ent_reg[3];
    assign m_r11 = ent_reg[4];
    assign m_r12 = ent_reg[5];
    assign m_r20 = ent_reg[6];
    assign m_r21 = ent_reg[7];
    assign m_r22 = ent_reg[8];
endmodule
`default_nettype wire

### rtl/qrm_checker.sv
// Port-level checks of the quaternion unit and their bind
`default_nettype none
`include "quaternion_to_rotation_matrix_unit_assert.svh"
module qrm_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic signed [15:0] s_quat_x,
    input wire logic signed [15:0] s_quat_y,
    input wire logic signed [15:0] s_quat_z,
    input wire logic signed [15:0] s_quat_w,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic signed [15:0] m_r00,
    input wire logic signed [15:0] m_r01,
    input wire logic signed [15:0] m_r02,
    input wire logic signed [15:0] m_r10,
    input wire logic signed [15:0] m_r11,
    input wire logic signed [15:0] m_r12,
    input wire logic signed [15:0] m_r20,
    input wire logic signed [15:0] m_r21,
    input wire logic signed [15:0] m_r22,
    input wire logic               m_zero_norm
);
    // a stalled result beat keeps m_valid, m_r00 and m_r12
    `QRM_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_r00) && $stable(m_r12))
    // an empty output register never blocks the input
    `QRM_ASSERT(a_ready_free, !m_valid |-> s_ready)
    // zero quaternion gives the identity
    `QRM_ASSERT(a_identity, m_valid && m_zero_norm |-> m_r00 == 16'sd16384 && m_r11 == 16'sd16384 && m_r22 == 16'sd16384 && m_r01 == 16'sd0 && m_r12 == 16'sd0 && m_r20 == 16'sd0)
    // diagonal stays within plus or minus one
    `QRM_ASSERT(a_range, m_valid |-> m_r00 <= 16'sd16384 && m_r00 >= -16'sd16384 && m_r11 <= 16'sd16384 && m_r11 >= -16'sd16384 && m_r22 <= 16'sd16384 && m_r22 >= -16'sd16384)
    // nothing leaves the pipe right after reset
    `QRM_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid)
endmodule

bind quaternion_to_rotation_matrix_unit qrm_checker u_qrm_checker (.*);
`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the quaternion to rotation matrix unit
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    localparam int LATENCY = qrm_pkg::OUT_FRAC_BITS + 5;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_RANDOM = 1500;
    localparam int N_DIRECTED = 16;

    typedef struct packed {
        logic signed [15:0] x, y, z, w;
    } quat_t;

    typedef struct packed {
        logic signed [15:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
        logic               zero_norm;
    } rot_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_quat_x = '0, s_quat_y = '0, s_quat_z = '0, s_quat_w = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [15:0] m_r00, m_r01, m_r02, m_r10, m_r11, m_r12, m_r20, m_r21, m_r22;
    logic m_zero_norm;

    rot_t expected_mats[$];
    int   error_count = 0;
    int   idle_count = 0;
    bit   quiet = 1'b0;
    bit   feed_done = 1'b0;

    always #10 aclk = ~aclk;

    quaternion_to_rotation_matrix_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_quat_x(s_quat_x), .s_quat_y(s_quat_y),
        .s_quat_z(s_quat_z), .s_quat_w(s_quat_w),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_r00(m_r00), .m_r01(m_r01), .m_r02(m_r02),
        .m_r10(m_r10), .m_r11(m_r11), .m_r12(m_r12),
        .m_r20(m_r20), .m_r21(m_r21), .m_r22(m_r22),
        .m_zero_norm(m_zero_norm)
    );

    // numerator * 2^frac / norm, rounded half away from zero, clamped to one
    function automatic logic signed [15:0] scale_entry(longint num, longint norm);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = ((mag << qrm_pkg::OUT_FRAC_BITS) + (norm >> 1)) / norm;
        if (q > (64'sd1 << qrm_pkg::OUT_FRAC_BITS))
            q = 64'sd1 << qrm_pkg::OUT_FRAC_BITS;
        return (num < 0) ? 16'(-q) : 16'(q);
    endfunction

    function automatic rot_t rotation_of(quat_t q);
        longint x, y, z, w, s;
        rot_t r;
        x = q.x; y = q.y; z = q.z; w = q.w;
        s = x*x + y*y + z*z + w*w;
        r = '0;
        if (s == 0) begin
            r.r00 = qrm_pkg::ONE_OUT; r.r11 = qrm_pkg::ONE_OUT; r.r22 = qrm_pkg::ONE_OUT;
            r.zero_norm = 1'b1;
            return r;
        end
        r.r00 = scale_entry(s - 2*(y*y + z*z), s);
        r.r01 = scale_entry(2*(x*y + w*z), s);
        r.r02 = scale_entry(2*(x*z - w*y), s);
        r.r10 = scale_entry(2*(x*y - w*z), s);
        r.r11 = scale_entry(s - 2*(x*x + z*z), s);
        r.r12 = scale_entry(2*(y*z + w*x), s);
        r.r20 = scale_entry(2*(x*z + w*y), s);
        r.r21 = scale_entry(2*(y*z - w*x), s);
        r.r22 = scale_entry(s - 2*(x*x + y*y), s);
        return r;
    endfunction

    // directed rows; typed-in matrix where has_fixed is set
    quat_t directed_quats [N_DIRECTED];
    rot_t  directed_mats  [N_DIRECTED];
    bit    has_fixed      [N_DIRECTED];

    initial begin
        rot_t ident, neg_x;
        ident = '0;
        ident.r00 = 16'sd16384; ident.r11 = 16'sd16384; ident.r22 = 16'sd16384;
        neg_x = '0;
        neg_x.r00 = 16'sd16384; neg_x.r11 = -16'sd16384; neg_x.r22 = -16'sd16384;
        foreach (has_fixed[i]) has_fixed[i] = 1'b0;
        // zero quaternion: identity with the flag
        directed_quats[0] = '{16'sd0, 16'sd0, 16'sd0, 16'sd0};
        directed_mats[0] = ident; directed_mats[0].zero_norm = 1'b1; has_fixed[0] = 1'b1;
        // unit w, tiny and extreme w
        directed_quats[1] = '{16'sd0, 16'sd0, 16'sd0, 16'sd4096};
        directed_mats[1] = ident; has_fixed[1] = 1'b1;
        directed_quats[2] = '{16'sd0, 16'sd0, 16'sd0, 16'sd1};
        directed_mats[2] = ident; has_fixed[2] = 1'b1;
        directed_quats[3] = '{16'sd0, 16'sd0, 16'sd0, -16'sd32768};
        directed_mats[3] = ident; has_fixed[3] = 1'b1;
        // pure x: half turn about x
        directed_quats[4] = '{16'sd32767, 16'sd0, 16'sd0, 16'sd0};
        directed_mats[4] = neg_x; has_fixed[4] = 1'b1;
        directed_quats[5] = '{-16'sd32768, 16'sd0, 16'sd0, 16'sd0};
        directed_mats[5] = neg_x; has_fixed[5] = 1'b1;
        directed_quats[6]  = '{16'sd0, 16'sd32767, 16'sd0, 16'sd0};
        directed_quats[7]  = '{16'sd0, 16'sd0, -16'sd32768, 16'sd0};
        directed_quats[8]  = '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767};
        directed_quats[9]  = '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768};
        directed_quats[10] = '{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768};
        directed_quats[11] = '{16'sd1, 16'sd1, 16'sd1, 16'sd1};
        directed_quats[12] = '{16'sd1, 16'sd0, 16'sd0, 16'sd1};
        directed_quats[13] = '{16'sd2896, 16'sd0, 16'sd0, 16'sd2896};
        directed_quats[14] = '{-16'sd1, 16'sd2, -16'sd3, 16'sd32767};
        directed_quats[15] = '{16'sd1, 16'sd1, 16'sd0, 16'sd0};
    end

    // sender: directed table, then random quaternions
    initial begin
        quat_t q;
        int    gap;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        for (int i = 0; i < N_DIRECTED + N_RANDOM; i++) begin
            if (i < N_DIRECTED) begin
                q = directed_quats[i];
            end else begin
                case ($urandom_range(0, 3))
                    0: q = quat_t'({$urandom, $urandom});
                    1: begin
                        q.x = 16'($signed($urandom_range(0, 8)) - 4);
                        q.y = 16'($signed($urandom_range(0, 8)) - 4);
                        q.z = 16'($signed($urandom_range(0, 8)) - 4);
                        q.w = 16'($signed($urandom_range(0, 8)) - 4);
                    end
                    2: begin
                        q = quat_t'({$urandom, $urandom});
                        q.x = q.x >>> 3; q.y = q.y >>> 3;
                        q.z = q.z >>> 3; q.w = q.w >>> 3;
                    end
                    default: begin
                        q = '0;
                        case ($urandom_range(0, 3))
                            0: q.x = 16'($urandom);
                            1: q.y = 16'($urandom);
                            2: q.z = 16'($urandom);
                            default: q.w = 16'($urandom);
                        endcase
                    end
                endcase
            end
            // idle the input in short bursts, none near the end
            if (!quiet && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 3);
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_valid  <= 1'b1;
            s_quat_x <= q.x; s_quat_y <= q.y; s_quat_z <= q.z; s_quat_w <= q.w;
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            if (i < N_DIRECTED && has_fixed[i])
                expected_mats.push_back(directed_mats[i]);
            else
                expected_mats.push_back(rotation_of(q));
            if (i == N_DIRECTED + N_RANDOM - 200)
                quiet = 1'b1;
        end
        s_valid <= 1'b0;
        feed_done = 1'b1;
    end

    // receiver stall: m_ready drops low in random bursts, none near the end
    initial begin
        int hold;
        @(posedge aclk);
        m_ready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (!quiet && m_ready && $urandom_range(0, 3) == 0) begin
                hold = $urandom_range(1, 3);
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    // compare each output beat with the oldest expected matrix
    always @(posedge aclk) begin
        rot_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_r00, m_r01, m_r02, m_r10, m_r11, m_r12, m_r20, m_r21, m_r22,
                    m_zero_norm};
            if (expected_mats.size() == 0) begin
                $display("%0t: unexpected beat, actual %h", $time, got);
                error_count++;
            end else begin
                want = expected_mats.pop_front();
                if (got != want) begin
                    $display("%0t: mismatch, expected %h actual %h", $time, want, got);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // drain, settle, report
    initial begin
        wait (feed_done);
        while (expected_mats.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire

### files.f
+incdir+rtl
rtl/qrm_pkg.sv
rtl/quaternion_to_rotation_matrix_unit.sv
rtl/qrm_checker.sv
tb/tb_top.sv
